>>> rtl/fcd_pkg.sv
// Shared types and character constants for the framed ASCII command decoder.
`timescale 1ns / 1ps

package fcd_pkg;

  // Frame characters
  localparam logic [7:0] CH_AT   = 8'h40;  // '@' opens a frame
  localparam logic [7:0] CH_HASH = 8'h23;  // '#' closes a frame
  localparam logic [7:0] CH_TAG  = 8'h54;  // 'T' header byte
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE = 8'h39;  // '9'

  // Body geometry: header, three command letters, four argument characters
  localparam int unsigned BODY_LEN = 8;
  localparam int unsigned IDX_W    = $clog2(BODY_LEN);
  localparam int unsigned POS_W    = 4;
  localparam logic [POS_W-1:0] POS_FULL = POS_W'(BODY_LEN);
  localparam logic [POS_W-1:0] POS_OVER = POS_W'(BODY_LEN + 1);

  localparam int unsigned VAL_W  = 14;
  localparam int unsigned KIND_W = 3;

  // Result kind codes
  typedef enum logic [KIND_W-1:0] {
    KIND_REJECT = 3'd0,
    KIND_START  = 3'd1,
    KIND_STOP   = 3'd2,
    KIND_KP     = 3'd3,
    KIND_KD     = 3'd4,
    KIND_ERR1   = 3'd5,
    KIND_ERR2   = 3'd6,
    KIND_LOCK   = 3'd7
  } kind_e;

  // One closed frame as handed from capture to decode
  typedef struct packed {
    logic                          len_ok;
    logic [BODY_LEN-1:0][7:0]      body;
  } frame_t;

  // Capture side push toward the queue
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_push_t;

endpackage

>>> rtl/framed_ascii_command_decoder.sv
// Top level of the framed ASCII command decoder: capture, frame queue, decode.
`timescale 1ns / 1ps

// Takes one received byte per cycle on the slave stream. '@' opens a frame at
// any time; the next eight bytes are kept and '#' closes it. A closed frame
// "@T" + command + four characters + "#" is decoded: CMDSTAR/CMDSTOP set the
// run/stop flags, PKP, PKD, ER1, ER2 and LOC load a four-digit decimal value
// (gains in thousandths). Each '#' inside an open frame gives one result item
// carrying the kind code on tuser (0 means rejected: wrong length, bad header,
// unknown command or a non-digit argument) and every held value on tdata.
// Bytes outside a frame give nothing. Throughput is one byte per cycle; the
// capture side stalls only when the frame queue (QUEUE_DEPTH entries) is full
// because results are not being taken. A result is offered once its '#' is
// accepted: the frame enters the queue on the accepting edge and is decoded
// into the output register when it heads the queue and the output slot is free.

module framed_ascii_command_decoder
  import fcd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [0] run_started, [1] run_stopped,
                                      // [15:2] kp_milli, [29:16] kd_milli,
                                      // [43:30] error_one, [57:44] error_two,
                                      // [71:58] lock correction value
  output logic [2:0]  m_axis_tuser    // [2:0] frame_kind
);

  frame_push_t      push;
  logic             q_full, q_valid, q_pop;
  frame_t           q_frame;
  logic             start, stop;
  logic [VAL_W-1:0] kp, kd, err1, err2, lock;
  logic             accept;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  fcd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .push_o   (push)
  );

  fcd_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(frame_t))
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push.valid),
    .data_i  (push.frame),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_frame)
  );

  fcd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (q_valid),
    .frame_i       (q_frame),
    .pop_o         (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .kind_o        (m_axis_tuser),
    .start_o       (start),
    .stop_o        (stop),
    .kp_o          (kp),
    .kd_o          (kd),
    .err1_o        (err1),
    .err2_o        (err2),
    .lock_o        (lock)
  );

  assign m_axis_tdata = {lock, err2, err1, kd, kp, stop, start};

endmodule

>>> rtl/fcd_front.sv
// Capture stage: tracks '@' ... '#' framing and collects the eight body bytes.
`timescale 1ns / 1ps

module fcd_front
  import fcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,   // byte taken this cycle
  input  logic [7:0]  byte_i,
  output frame_push_t push_o
);

  logic                     cap_q, cap_d;
  logic [POS_W-1:0]         pos_q, pos_d;
  logic [BODY_LEN-1:0][7:0] body_q;
  logic                     wr_en;

  // Framing control
  always_comb begin
    cap_d             = cap_q;
    pos_d             = pos_q;
    wr_en             = 1'b0;
    push_o.valid      = 1'b0;
    push_o.frame.len_ok = (pos_q == POS_FULL);
    push_o.frame.body   = body_q;
    if (accept_i) begin
      if (byte_i == CH_AT) begin
        cap_d = 1'b1;
        pos_d = '0;
      end else if (cap_q) begin
        if (byte_i == CH_HASH) begin
          push_o.valid = 1'b1;
          cap_d        = 1'b0;
          pos_d        = '0;
        end else if (pos_q < POS_FULL) begin
          wr_en = 1'b1;
          pos_d = pos_q + POS_W'(1);
        end else begin
          // overlong frame: drop the byte, remember the overrun
          pos_d = POS_OVER;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 1'b0;
      pos_q <= '0;
    end else begin
      cap_q <= cap_d;
      pos_q <= pos_d;
    end
  end

  // Body byte store, no reset needed
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      body_q[pos_q[IDX_W-1:0]] <= byte_i;
    end
  end

  // Position never runs past the overrun mark
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_OVER)
    else $error("capture position out of range");

  // Position only moves while a frame is open
  a_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cap_q |-> pos_q == '0)
    else $error("position nonzero while idle");

  // A frame is closed only from an open capture
  a_push_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> cap_q)
    else $error("frame push without capture");

endmodule

>>> rtl/fcd_queue.sv
// Short frame queue between capture and decode.
`timescale 1ns / 1ps

module fcd_queue #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue count overflow");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with pointers apart");

endmodule

>>> rtl/fcd_back.sv
// Decode stage: checks a closed frame, updates the held values, drives the result.
`timescale 1ns / 1ps

module fcd_back
  import fcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              frame_valid_i,
  input  frame_t            frame_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [KIND_W-1:0] kind_o,
  output logic              start_o,
  output logic              stop_o,
  output logic [VAL_W-1:0]  kp_o,
  output logic [VAL_W-1:0]  kd_o,
  output logic [VAL_W-1:0]  err1_o,
  output logic [VAL_W-1:0]  err2_o,
  output logic [VAL_W-1:0]  lock_o
);

  logic             out_valid_q;
  kind_e            kind_q, kind_d;
  logic             start_q, start_d, stop_q, stop_d;
  logic [VAL_W-1:0] kp_q, kp_d, kd_q, kd_d, err1_q, err1_d, err2_q, err2_d;
  logic [VAL_W-1:0] lock_q, lock_d;
  logic             all_digits;
  logic [3:0]       dig [4];
  logic [VAL_W-1:0] value;
  logic             hdr_ok;

  function automatic logic cmd_is(frame_t f, logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return f.body[1] == a && f.body[2] == b && f.body[3] == c;
  endfunction

  function automatic logic arg_is(frame_t f, logic [7:0] a, logic [7:0] b,
                                  logic [7:0] c, logic [7:0] d);
    return f.body[4] == a && f.body[5] == b && f.body[6] == c && f.body[7] == d;
  endfunction

  // Slot free or being emptied: take the next frame
  assign pop_o = frame_valid_i && (!out_valid_q || out_ready_i);

  // Argument digits and their decimal value
  always_comb begin
    all_digits = 1'b1;
    for (int i = 0; i < 4; i++) begin
      dig[i] = 4'(frame_i.body[4+i] - CH_ZERO);
      if (frame_i.body[4+i] < CH_ZERO || frame_i.body[4+i] > CH_NINE) begin
        all_digits = 1'b0;
      end
    end
    value = VAL_W'(dig[0]) * VAL_W'(1000) + VAL_W'(dig[1]) * VAL_W'(100)
          + VAL_W'(dig[2]) * VAL_W'(10) + VAL_W'(dig[3]);
  end

  assign hdr_ok = frame_i.len_ok && (frame_i.body[0] == CH_TAG);

  // Command decode
  always_comb begin
    kind_d  = KIND_REJECT;
    start_d = start_q;
    stop_d  = stop_q;
    kp_d    = kp_q;
    kd_d    = kd_q;
    err1_d  = err1_q;
    err2_d  = err2_q;
    lock_d  = lock_q;
    if (hdr_ok) begin
      if (cmd_is(frame_i, "C", "M", "D")) begin
        if (arg_is(frame_i, "S", "T", "A", "R")) begin
          kind_d  = KIND_START;
          start_d = 1'b1;
          stop_d  = 1'b0;
        end else if (arg_is(frame_i, "S", "T", "O", "P")) begin
          kind_d  = KIND_STOP;
          start_d = 1'b0;
          stop_d  = 1'b1;
        end
      end else if (all_digits) begin
        if (cmd_is(frame_i, "P", "K", "P")) begin
          kind_d = KIND_KP;
          kp_d   = value;
        end else if (cmd_is(frame_i, "P", "K", "D")) begin
          kind_d = KIND_KD;
          kd_d   = value;
        end else if (cmd_is(frame_i, "E", "R", "1")) begin
          kind_d = KIND_ERR1;
          err1_d = value;
        end else if (cmd_is(frame_i, "E", "R", "2")) begin
          kind_d = KIND_ERR2;
          err2_d = value;
        end else if (cmd_is(frame_i, "L", "O", "C")) begin
          kind_d = KIND_LOCK;
          lock_d = value;
        end
      end
    end
  end

  // Held values change only when a new result loads, so they double as output data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      kind_q      <= KIND_REJECT;
      start_q     <= 1'b0;
      stop_q      <= 1'b0;
      kp_q        <= '0;
      kd_q        <= '0;
      err1_q      <= '0;
      err2_q      <= '0;
      lock_q      <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        kind_q      <= kind_d;
        start_q     <= start_d;
        stop_q      <= stop_d;
        kp_q        <= kp_d;
        kd_q        <= kd_d;
        err1_q      <= err1_d;
        err2_q      <= err2_d;
        lock_q      <= lock_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign start_o     = start_q;
  assign stop_o      = stop_q;
  assign kp_o        = kp_q;
  assign kd_o        = kd_q;
  assign err1_o      = err1_q;
  assign err2_o      = err2_q;
  assign lock_o      = lock_q;

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_q && stop_q))
    else $error("start and stop both held");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && kind_d == KIND_REJECT) |=>
      ($stable(kp_q) && $stable(kd_q) && $stable(err1_q) && $stable(err2_q)
       && $stable(lock_q) && $stable(start_q) && $stable(stop_q)))
    else $error("rejected frame changed held values");

  a_values_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kp_q <= VAL_W'(9999) && kd_q <= VAL_W'(9999) && err1_q <= VAL_W'(9999)
    && err2_q <= VAL_W'(9999) && lock_q <= VAL_W'(9999))
    else $error("held value above four digits");

endmodule
